// File: rtl/page_frame_table_fifo_lru_assert.svh
// ----------------------------------------------------------------------------
// Page frame table assertion macros
// Clocked implication checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_TABLE_FIFO_LRU_ASSERT_SVH
`define PAGE_FRAME_TABLE_FIFO_LRU_ASSERT_SVH

// Same-cycle implication.
`define PFTFL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pftfl: same-cycle check failed");

// Next-cycle implication.
`define PFTFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pftfl: next-cycle check failed");

`endif

// File: rtl/pftfl_pkg.sv
// ----------------------------------------------------------------------------
// pftfl_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pftfl_pkg;

  localparam int FRAMES      = 16;
  localparam int FRAME_IDX_W = $clog2(FRAMES);
  localparam int FRAME_CNT_W = $clog2(FRAMES + 1);
  localparam int PAGE_W      = 8;
  localparam int STAMP_W     = 32;
  localparam int FAULT_W     = 16;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [FRAME_CNT_W-1:0] FRAMES_RESET = FRAME_CNT_W'(FRAMES);

  typedef enum logic {
    MODE_FIFO = 1'b0,
    MODE_LRU  = 1'b1
  } repl_mode_t;

  // Register select is byte address bit 2.
  typedef enum logic {
    REG_REPL_MODE     = 1'b0,
    REG_FRAMES_IN_USE = 1'b1
  } reg_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load;        // capture accepted page
    logic scan_start;  // seed victim search with frame 0
    logic scan_step;   // compare one more frame
    logic commit;      // update table, load result
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic free_found;
    logic scan_last;
  } stat_t;

endpackage

// File: rtl/pftfl_cfg.sv
// ----------------------------------------------------------------------------
// pftfl_cfg
// APB register file: replacement mode and active frame count.
// ----------------------------------------------------------------------------
module pftfl_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pftfl_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [pftfl_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pftfl_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                 pready,
  output pftfl_pkg::repl_mode_t                repl_mode,
  output logic [pftfl_pkg::FRAME_CNT_W-1:0]    frames_in_use
);

  pftfl_pkg::reg_sel_t sel;
  logic                wr;

  assign pready = 1'b1;
  assign sel    = pftfl_pkg::reg_sel_t'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      repl_mode     <= pftfl_pkg::MODE_FIFO;
      frames_in_use <= pftfl_pkg::FRAMES_RESET;
    end else if (wr) begin
      unique case (sel)
        pftfl_pkg::REG_REPL_MODE:     repl_mode <= pftfl_pkg::repl_mode_t'(pwdata[0]);
        pftfl_pkg::REG_FRAMES_IN_USE: frames_in_use <= pwdata[pftfl_pkg::FRAME_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      pftfl_pkg::REG_REPL_MODE:     prdata[0] = repl_mode;
      pftfl_pkg::REG_FRAMES_IN_USE: prdata[pftfl_pkg::FRAME_CNT_W-1:0] = frames_in_use;
      default: ;
    endcase
  end

endmodule

// File: rtl/pftfl_ctrl.sv
// ----------------------------------------------------------------------------
// pftfl_ctrl
// Sequencer: accept, lookup, optional victim scan, commit into output stage.
// ----------------------------------------------------------------------------
module pftfl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pftfl_pkg::stat_t  stat,
  output pftfl_pkg::cmd_t   cmd
);

  pftfl_pkg::state_t state, state_next;
  logic              out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pftfl_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      pftfl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = pftfl_pkg::ST_LOOK;
        end
      end
      pftfl_pkg::ST_LOOK: begin
        if (stat.hit || stat.free_found) begin
          if (out_free) begin
            cmd.commit = 1'b1;
            state_next = pftfl_pkg::ST_IDLE;
          end
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = pftfl_pkg::ST_SCAN;
        end
      end
      pftfl_pkg::ST_SCAN: begin
        if (!stat.scan_last) begin
          cmd.scan_step = 1'b1;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_next = pftfl_pkg::ST_IDLE;
        end
      end
      default: state_next = pftfl_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/pftfl_dpath.sv
// ----------------------------------------------------------------------------
// pftfl_dpath
// Frame table, parallel tag/free lookup, serial oldest-stamp scan, counters
// and the result register.
// ----------------------------------------------------------------------------
module pftfl_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pftfl_pkg::cmd_t                      cmd,
  output pftfl_pkg::stat_t                     stat,
  input  logic [pftfl_pkg::PAGE_W-1:0]         page_number,
  input  pftfl_pkg::repl_mode_t                repl_mode,
  input  logic [pftfl_pkg::FRAME_CNT_W-1:0]    frames_in_use,
  output logic                                 hit,
  output logic [pftfl_pkg::FRAME_IDX_W-1:0]    frame_index,
  output logic                                 evicted_valid,
  output logic [pftfl_pkg::PAGE_W-1:0]         evicted_page,
  output logic [pftfl_pkg::FAULT_W-1:0]        fault_total
);

  localparam int N  = pftfl_pkg::FRAMES;
  localparam int IW = pftfl_pkg::FRAME_IDX_W;
  localparam int CW = pftfl_pkg::FRAME_CNT_W;
  localparam int SW = pftfl_pkg::STAMP_W;
  localparam int FW = pftfl_pkg::FAULT_W;

  // table
  logic [N-1:0]                    frame_valid;
  logic [pftfl_pkg::PAGE_W-1:0]    frame_page    [N];
  logic [SW-1:0]                   arrival_stamp [N];
  logic [SW-1:0]                   access_stamp  [N];
  logic [SW-1:0]                   access_clock;
  logic [FW-1:0]                   fault_counter;

  logic [pftfl_pkg::PAGE_W-1:0]    page;

  // victim scan
  logic [CW-1:0]                   scan_idx;
  logic [IW-1:0]                   best_idx;
  logic [SW-1:0]                   best_stamp;
  logic [SW-1:0]                   scan_stamp;
  logic [SW-1:0]                   first_stamp;

  logic [CW-1:0]                   n_active;
  logic [N-1:0]                    match_vec;
  logic [N-1:0]                    free_vec;
  logic [IW-1:0]                   hit_idx;
  logic [IW-1:0]                   free_idx;
  logic [IW-1:0]                   slot;
  logic                            evict;
  logic [FW-1:0]                   fault_next;

  // Out-of-range frame counts clamp to 1..FRAMES.
  always_comb begin
    if (frames_in_use == '0) begin
      n_active = CW'(1);
    end else if (frames_in_use > CW'(N)) begin
      n_active = CW'(N);
    end else begin
      n_active = frames_in_use;
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_vec[i] = (CW'(i) < n_active) && frame_valid[i] && (frame_page[i] == page);
      free_vec[i]  = (CW'(i) < n_active) && !frame_valid[i];
    end
  end

  // Lowest index wins.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_idx = IW'(i);
      if (free_vec[i])  free_idx = IW'(i);
    end
  end

  assign scan_stamp  = (repl_mode == pftfl_pkg::MODE_LRU) ?
                       access_stamp[scan_idx[IW-1:0]] : arrival_stamp[scan_idx[IW-1:0]];
  assign first_stamp = (repl_mode == pftfl_pkg::MODE_LRU) ? access_stamp[0] : arrival_stamp[0];

  assign stat.hit        = |match_vec;
  assign stat.free_found = |free_vec;
  assign stat.scan_last  = (scan_idx >= n_active);

  assign evict = !stat.hit && !stat.free_found;
  assign slot  = stat.hit ? hit_idx : (stat.free_found ? free_idx : best_idx);

  assign fault_next = (!stat.hit && (fault_counter != '1)) ? fault_counter + FW'(1)
                                                           : fault_counter;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page <= page_number;
    end
    if (cmd.scan_start) begin
      scan_idx   <= CW'(1);
      best_idx   <= '0;
      best_stamp <= first_stamp;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + CW'(1);
      if (scan_stamp < best_stamp) begin
        best_idx   <= scan_idx[IW-1:0];
        best_stamp <= scan_stamp;
      end
    end
    if (cmd.commit) begin
      access_stamp[slot] <= access_clock;
      if (!stat.hit) begin
        frame_page[slot]    <= page;
        arrival_stamp[slot] <= access_clock;
      end
      hit           <= stat.hit;
      frame_index   <= slot;
      evicted_valid <= evict;
      evicted_page  <= evict ? frame_page[slot] : '0;
      fault_total   <= fault_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid   <= '0;
      access_clock  <= '0;
      fault_counter <= '0;
    end else if (cmd.commit) begin
      frame_valid[slot] <= 1'b1;
      fault_counter     <= fault_next;
      if (access_clock != '1) begin
        access_clock <= access_clock + SW'(1);
      end
    end
  end

endmodule

// File: rtl/page_frame_table_fifo_lru.sv
// ----------------------------------------------------------------------------
// page_frame_table_fifo_lru
// Fully associative page frame table with FIFO or LRU replacement.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   in       | in_valid / in_ready  | page_number
//   out      | out_valid / out_ready| hit, frame_index, evicted_valid,
//            |                      | evicted_page, fault_total
//   cfg      | APB psel/penable     | paddr, pwdata, prdata (mode, frame count)
//
// Steps: a hit or a fill into a free frame is accepted, then looked up and
//   committed. An eviction adds an oldest-stamp scan over the n active
//   frames, which reads one frame's stamp per cycle, before the commit.
// Reset: synchronous; frees every frame, clears the access clock and the
//   fault count, mode FIFO, 16 frames active.
// Stalls: the result sits in an output register; a new transaction is taken
//   while it waits, and only the commit of that next transaction holds off
//   until the output register is free.
// ----------------------------------------------------------------------------
module page_frame_table_fifo_lru (
  input  logic                                 clk,
  input  logic                                 rst,
  // input transaction
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [pftfl_pkg::PAGE_W-1:0]         page_number,
  // result transaction
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 hit,
  output logic [pftfl_pkg::FRAME_IDX_W-1:0]    frame_index,
  output logic                                 evicted_valid,
  output logic [pftfl_pkg::PAGE_W-1:0]         evicted_page,
  output logic [pftfl_pkg::FAULT_W-1:0]        fault_total,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pftfl_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [pftfl_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pftfl_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                 pready
);

  pftfl_pkg::repl_mode_t                repl_mode;
  logic [pftfl_pkg::FRAME_CNT_W-1:0]    frames_in_use;
  pftfl_pkg::cmd_t                      cmd;
  pftfl_pkg::stat_t                     stat;

  // Register file: the user must write it only while no transaction is in flight; the block does not enforce this.
  pftfl_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .repl_mode     (repl_mode),
    .frames_in_use (frames_in_use)
  );

  // Sequencer owns the handshakes and the output valid flag.
  pftfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Table, search and result payload.
  pftfl_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .page_number   (page_number),
    .repl_mode     (repl_mode),
    .frames_in_use (frames_in_use),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

endmodule

// File: rtl/pftfl_checker.sv
// ----------------------------------------------------------------------------
// pftfl_checker
// Port-level checks on the page frame table, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_frame_table_fifo_lru_assert.svh"

module pftfl_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 hit,
  input logic [pftfl_pkg::FRAME_IDX_W-1:0]    frame_index,
  input logic                                 evicted_valid,
  input logic [pftfl_pkg::PAGE_W-1:0]         evicted_page,
  input logic [pftfl_pkg::FAULT_W-1:0]        fault_total
);

  // Stalled result holds.
  `PFTFL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(hit) && $stable(frame_index) && $stable(evicted_page) && $stable(fault_total))

  // One transaction at a time: no accept right after an accept.
  `PFTFL_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // A hit never evicts.
  `PFTFL_ASSERT_IMP(a_hit_no_evict, clk, rst, out_valid && hit, !evicted_valid && (evicted_page == '0))

  // A fault has been counted.
  `PFTFL_ASSERT_IMP(a_fault_counted, clk, rst, out_valid && !hit, fault_total != '0)

endmodule

bind page_frame_table_fifo_lru pftfl_checker u_pftfl_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .hit           (hit),
  .frame_index   (frame_index),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page),
  .fault_total   (fault_total)
);
